// ===== src/mimp_pkg.sv =====
// shared types and byte codes for the midi input message parser
`timescale 1ns / 1ps

package mimp_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_REALTIME = 2'd0,
		KIND_MESSAGE  = 2'd1,
		KIND_SYSEX    = 2'd2
	} kind_t;

	// system bytes
	localparam logic [7:0] SYS_SOX       = 8'hF0;
	localparam logic [7:0] SYS_MTC_QF    = 8'hF1;
	localparam logic [7:0] SYS_SONG_POS  = 8'hF2;
	localparam logic [7:0] SYS_SONG_SEL  = 8'hF3;
	localparam logic [7:0] SYS_EOX       = 8'hF7;
	localparam logic [7:0] SYS_CLOCK     = 8'hF8;
	localparam logic [7:0] SYS_START     = 8'hFA;
	localparam logic [7:0] SYS_CONTINUE  = 8'hFB;
	localparam logic [7:0] SYS_STOP      = 8'hFC;

	// upper nibbles of interest
	localparam logic [3:0] NIB_SYSTEM    = 4'hF;
	localparam logic [3:0] NIB_PROGRAM   = 4'hC;
	localparam logic [3:0] NIB_PRESSURE  = 4'hD;

	// parser state
	typedef struct packed {
		logic [7:0] running_status;
		logic [1:0] needed_count;
		logic [1:0] received_count;
		logic [6:0] data0;
		logic [6:0] data1;
		logic       sysex_active;
	} state_t;

	// one decoded result
	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] status_byte;
		logic [1:0] data_count;
		logic [6:0] first_data;
		logic [6:0] second_data;
	} result_t;

endpackage

// ===== src/mimp_if.sv =====
// valid/ready channel interfaces for received bytes and parsed results
`timescale 1ns / 1ps

interface mimp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mimp_msg_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] status_byte;
	logic [1:0] data_count;
	logic [6:0] first_data;
	logic [6:0] second_data;

	modport source (output valid, output kind, output status_byte, output data_count,
		output first_data, output second_data, input ready);
	modport sink   (input valid, input kind, input status_byte, input data_count,
		input first_data, input second_data, output ready);
endinterface

// ===== src/midi_input_message_parser_unit.sv =====
// a received byte goes through the input register and the decode logic into the result register
// throughput: one byte per cycle while the result side takes beats
// an input register and a result register part the two channels
// reset (arst_n low): parser state, running status and all valid flags clear
// bytes that cause no result leave only a state change
`timescale 1ns / 1ps

module midi_input_message_parser_unit (
	input  logic             clk,
	input  logic             arst_n,
	mimp_rx_if.sink          rx,
	mimp_msg_if.source       msg
);

	logic              valid_s1;
	logic [7:0]        rx_byte_s1;
	mimp_pkg::state_t  st_q;
	mimp_pkg::state_t  st_nxt;
	mimp_pkg::result_t res;
	mimp_pkg::result_t out_q;
	logic              advance;
	logic              in_ready;

	// stage 1 moves on when the result register is free or drained
	assign advance  = !out_q.valid || msg.ready;
	assign in_ready = advance || !valid_s1;
	assign rx.ready = in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && rx.valid) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	mimp_decode u_decode (
		.rx_byte (rx_byte_s1),
		.st      (st_q),
		.st_nxt  (st_nxt),
		.res     (res)
	);

	// parser state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			out_q <= '0;
		end else if (advance) begin
			if (valid_s1) begin
				st_q <= st_nxt;
			end
			if (valid_s1 && res.valid) begin
				out_q <= res;
			end else begin
				out_q.valid <= 1'b0;
			end
		end
	end

	// result beat
	assign msg.valid       = out_q.valid;
	assign msg.kind        = out_q.kind;
	assign msg.status_byte = out_q.status_byte;
	assign msg.data_count  = out_q.data_count;
	assign msg.first_data  = out_q.first_data;
	assign msg.second_data = out_q.second_data;

endmodule

// ===== src/mimp_decode.sv =====
// next-state and result logic for one received byte
`timescale 1ns / 1ps

module mimp_decode (
	input  logic [7:0]       rx_byte,
	input  mimp_pkg::state_t st,
	output mimp_pkg::state_t st_nxt,
	output mimp_pkg::result_t res
);

	logic [1:0] cnt_inc;

	always_comb begin
		st_nxt  = st;
		res     = '0;
		cnt_inc = st.received_count + 2'd1;

		if (rx_byte[7:4] == mimp_pkg::NIB_SYSTEM) begin
			// system bytes
			unique case (rx_byte) inside
				mimp_pkg::SYS_CLOCK, mimp_pkg::SYS_START,
				mimp_pkg::SYS_CONTINUE, mimp_pkg::SYS_STOP: begin
					res.valid       = 1'b1;
					res.kind        = mimp_pkg::KIND_REALTIME;
					res.status_byte = rx_byte;
				end
				mimp_pkg::SYS_MTC_QF, mimp_pkg::SYS_SONG_SEL: begin
					st_nxt.received_count = 2'd0;
					st_nxt.running_status = rx_byte;
					st_nxt.needed_count   = 2'd1;
				end
				mimp_pkg::SYS_SONG_POS: begin
					st_nxt.received_count = 2'd0;
					st_nxt.running_status = rx_byte;
					st_nxt.needed_count   = 2'd2;
				end
				mimp_pkg::SYS_SOX: begin
					st_nxt.sysex_active = 1'b1;
				end
				mimp_pkg::SYS_EOX: begin
					st_nxt.sysex_active = 1'b0;
				end
				default: begin
				end
			endcase
		end else if (rx_byte[7]) begin
			// channel status byte
			st_nxt.sysex_active   = 1'b0;
			st_nxt.received_count = 2'd0;
			st_nxt.running_status = rx_byte;
			st_nxt.needed_count   = (rx_byte[7:4] == mimp_pkg::NIB_PROGRAM ||
				rx_byte[7:4] == mimp_pkg::NIB_PRESSURE) ? 2'd1 : 2'd2;
		end else if (st.sysex_active) begin
			// sysex data passes through
			res.valid      = 1'b1;
			res.kind       = mimp_pkg::KIND_SYSEX;
			res.first_data = rx_byte[6:0];
		end else if (st.running_status != 8'd0) begin
			// gather data under running status
			if (st.received_count[0]) begin
				st_nxt.data1 = rx_byte[6:0];
			end else begin
				st_nxt.data0 = rx_byte[6:0];
			end
			st_nxt.received_count = cnt_inc;
			if (cnt_inc >= st.needed_count) begin
				st_nxt.received_count = 2'd0;
				res.valid       = 1'b1;
				res.kind        = mimp_pkg::KIND_MESSAGE;
				res.status_byte = st.running_status;
				res.data_count  = st.needed_count;
				res.first_data  = st_nxt.data0;
				res.second_data = st_nxt.data1;
			end
		end
	end

endmodule

// ===== src/mimp_checker.sv =====
// port checker for the midi input message parser and its bind
`timescale 1ns / 1ps

module mimp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       msg_valid,
	input logic       msg_ready,
	input logic [1:0] kind,
	input logic [7:0] status_byte,
	input logic [1:0] data_count,
	input logic [6:0] first_data,
	input logic [6:0] second_data
);

	// a realtime beat carries only a clock, start, continue or stop byte
	a_realtime: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && kind == mimp_pkg::KIND_REALTIME |->
			(status_byte == mimp_pkg::SYS_CLOCK || status_byte == mimp_pkg::SYS_START ||
			 status_byte == mimp_pkg::SYS_CONTINUE || status_byte == mimp_pkg::SYS_STOP) &&
			data_count == 2'd0 && first_data == 7'd0 && second_data == 7'd0)
		else $error("realtime beat malformed");

	// a sysex beat carries only its data byte
	a_sysex: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && kind == mimp_pkg::KIND_SYSEX |->
			status_byte == 8'd0 && data_count == 2'd0 && second_data == 7'd0)
		else $error("sysex beat malformed");

	// a message has a status and one or two data bytes
	a_message: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && kind == mimp_pkg::KIND_MESSAGE |->
			status_byte[7] && (data_count == 2'd1 || data_count == 2'd2))
		else $error("message beat malformed");

	// no unused kind code
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid |-> kind != 2'd3)
		else $error("bad result kind");

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_ready |=> msg_valid && $stable(kind) && $stable(status_byte) &&
			$stable(data_count) && $stable(first_data) && $stable(second_data))
		else $error("stalled result beat changed");

endmodule

bind midi_input_message_parser_unit mimp_checker u_mimp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.msg_valid   (msg.valid),
	.msg_ready   (msg.ready),
	.kind        (msg.kind),
	.status_byte (msg.status_byte),
	.data_count  (msg.data_count),
	.first_data  (msg.first_data),
	.second_data (msg.second_data)
);

// ===== dv/midi_input_message_parser_unit_tb.sv =====
// testbench for the midi input message parser: directed byte table, then random byte streams
`timescale 1ns / 1ps

module midi_input_message_parser_unit_tb;

	localparam int CLK_HALF     = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 8;
	localparam int PHASE_ITEMS  = 140;
	localparam int REPORT_LIMIT = 10;

	// one result beat as the parser produces it
	typedef struct packed {
		mimp_pkg::kind_t kind;
		logic [7:0]      status;
		logic [1:0]      count;
		logic [6:0]      d0;
		logic [6:0]      d1;
	} msg_beat_t;

	// what to expect from one byte: typed-in result, or left to the parser model
	typedef struct packed {
		logic      typed;
		logic      has_res;
		msg_beat_t res;
	} plan_t;

	typedef struct packed {
		logic [7:0] value;
		plan_t      plan;
	} row_t;

	logic clk;
	logic arst_n;

	mimp_rx_if  rx_ch ();
	mimp_msg_if msg_ch ();

	midi_input_message_parser_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.msg    (msg_ch)
	);

	// parser model state
	logic [7:0] cur_status;
	logic [1:0] need_cnt;
	logic [1:0] got_cnt;
	logic [6:0] data_pair [2];
	logic       in_sysex;

	msg_beat_t   pending_msgs [$];
	plan_t       byte_plans [$];
	int          send_idle_pct;
	int          recv_stall_pct;
	int          rand_items;
	int          bytes_sent;
	int          fail_count;
	int          n_realtime;
	int          n_message;
	int          n_sysex;
	int unsigned cycle_count;
	row_t        dir_rows [26];

	// parser model: one byte in, at most one result out
	function automatic bit parse_byte(input logic [7:0] b, output msg_beat_t r);
		r = '0;
		if (b[7:4] == mimp_pkg::NIB_SYSTEM) begin
			case (b)
				mimp_pkg::SYS_CLOCK, mimp_pkg::SYS_START, mimp_pkg::SYS_CONTINUE,
				mimp_pkg::SYS_STOP: begin
					r.kind   = mimp_pkg::KIND_REALTIME;
					r.status = b;
					return 1'b1;
				end
				mimp_pkg::SYS_MTC_QF, mimp_pkg::SYS_SONG_SEL: begin
					got_cnt    = 2'd0;
					cur_status = b;
					need_cnt   = 2'd1;
				end
				mimp_pkg::SYS_SONG_POS: begin
					got_cnt    = 2'd0;
					cur_status = b;
					need_cnt   = 2'd2;
				end
				mimp_pkg::SYS_SOX: in_sysex = 1'b1;
				mimp_pkg::SYS_EOX: in_sysex = 1'b0;
				default: ;
			endcase
			return 1'b0;
		end
		// channel status
		if (b[7]) begin
			in_sysex   = 1'b0;
			got_cnt    = 2'd0;
			cur_status = b;
			need_cnt   = (b[7:4] == mimp_pkg::NIB_PROGRAM ||
				b[7:4] == mimp_pkg::NIB_PRESSURE) ? 2'd1 : 2'd2;
			return 1'b0;
		end
		if (in_sysex) begin
			r.kind = mimp_pkg::KIND_SYSEX;
			r.d0   = b[6:0];
			return 1'b1;
		end
		if (cur_status == 8'd0)
			return 1'b0;
		// gather data under running status
		data_pair[got_cnt[0]] = b[6:0];
		got_cnt = got_cnt + 2'd1;
		if (got_cnt >= need_cnt) begin
			got_cnt  = 2'd0;
			r.kind   = mimp_pkg::KIND_MESSAGE;
			r.status = cur_status;
			r.count  = need_cnt;
			r.d0     = data_pair[0];
			r.d1     = data_pair[1];
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// table rows: left to the model, typed with no result, typed with a result
	function automatic row_t row_free(input logic [7:0] v);
		row_t r;
		r       = '0;
		r.value = v;
		return r;
	endfunction

	function automatic row_t row_none(input logic [7:0] v);
		row_t r;
		r            = '0;
		r.value      = v;
		r.plan.typed = 1'b1;
		return r;
	endfunction

	function automatic row_t row_out(input logic [7:0] v, input mimp_pkg::kind_t k,
			input logic [7:0] st, input logic [1:0] cnt, input logic [6:0] d0,
			input logic [6:0] d1);
		row_t r;
		r              = '0;
		r.value        = v;
		r.plan.typed   = 1'b1;
		r.plan.has_res = 1'b1;
		r.plan.res     = '{kind: k, status: st, count: cnt, d0: d0, d1: d1};
		return r;
	endfunction

	function automatic logic [7:0] pick_realtime();
		case ($urandom_range(0, 3))
			0:       return mimp_pkg::SYS_CLOCK;
			1:       return mimp_pkg::SYS_START;
			2:       return mimp_pkg::SYS_CONTINUE;
			default: return mimp_pkg::SYS_STOP;
		endcase
	endfunction

	function automatic logic [7:0] pick_channel_status();
		return {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
	endfunction

	task automatic report_failure(input string why, input msg_beat_t want, input msg_beat_t got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display({"%0t %s: expected kind=%0d status=%02h count=%0d d0=%02h d1=%02h,",
				" got kind=%0d status=%02h count=%0d d0=%02h d1=%02h"},
				$realtime, why, want.kind, want.status, want.count, want.d0, want.d1,
				got.kind, got.status, got.count, got.d0, got.d1);
	endtask

	// clock and reset
	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// run watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_msgs.size());
			$display("midi_input_message_parser_unit_tb NOT OK");
			$finish;
		end
	end

	// result side stalls
	initial begin
		msg_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			msg_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// predict on each accepted byte, check each accepted result beat
	msg_beat_t pred_beat;
	msg_beat_t seen_beat;
	msg_beat_t want_beat;
	plan_t     cur_plan;
	bit        pred_hit;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready) begin
				cur_plan = byte_plans.pop_front();
				pred_hit = parse_byte(rx_ch.rx_byte, pred_beat);
				if (cur_plan.typed) begin
					if (cur_plan.has_res)
						pending_msgs.push_back(cur_plan.res);
				end else if (pred_hit) begin
					pending_msgs.push_back(pred_beat);
				end
			end
			if (msg_ch.valid && msg_ch.ready) begin
				seen_beat.kind   = mimp_pkg::kind_t'(msg_ch.kind);
				seen_beat.status = msg_ch.status_byte;
				seen_beat.count  = msg_ch.data_count;
				seen_beat.d0     = msg_ch.first_data;
				seen_beat.d1     = msg_ch.second_data;
				case (seen_beat.kind)
					mimp_pkg::KIND_REALTIME: n_realtime++;
					mimp_pkg::KIND_MESSAGE:  n_message++;
					default:                 n_sysex++;
				endcase
				if (pending_msgs.size() == 0) begin
					report_failure("unexpected beat", '0, seen_beat);
				end else begin
					want_beat = pending_msgs.pop_front();
					if (seen_beat !== want_beat)
						report_failure("mismatch", want_beat, seen_beat);
				end
			end
		end
	end

	// offer one byte, with random idle cycles ahead of it
	task automatic put_byte(input logic [7:0] b, input plan_t p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_plans.push_back(p);
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_counted(input logic [7:0] b);
		put_byte(b, '0);
		rand_items++;
	endtask

	// data bytes with the odd realtime byte mixed in
	task automatic send_data(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_counted(pick_realtime());
			send_counted(8'($urandom_range(0, 127)));
		end
	endtask

	// one random well-formed sequence, or a burst of noise
	task automatic gen_sequence();
		logic [7:0] st;
		int         need;
		int         sel;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			// channel message, repeated under running status, sometimes cut short
			st   = pick_channel_status();
			need = (st[7:4] == mimp_pkg::NIB_PROGRAM || st[7:4] == mimp_pkg::NIB_PRESSURE) ?
				1 : 2;
			send_counted(st);
			send_data(need * $urandom_range(1, 3) + ($urandom_range(0, 9) == 0));
		end else if (sel < 55) begin
			// system common
			case ($urandom_range(0, 2))
				0:       st = mimp_pkg::SYS_MTC_QF;
				1:       st = mimp_pkg::SYS_SONG_POS;
				default: st = mimp_pkg::SYS_SONG_SEL;
			endcase
			need = (st == mimp_pkg::SYS_SONG_POS) ? 2 : 1;
			send_counted(st);
			send_data(need * $urandom_range(1, 2));
		end else if (sel < 72) begin
			// sysex block, closed by end of sysex or broken by a channel status
			send_counted(mimp_pkg::SYS_SOX);
			send_data($urandom_range(0, 6));
			if ($urandom_range(0, 4) == 0)
				send_counted(pick_channel_status());
			else
				send_counted(mimp_pkg::SYS_EOX);
		end else if (sel < 82) begin
			send_counted(pick_realtime());
		end else begin
			// noise over the full byte range
			repeat ($urandom_range(1, 4)) send_counted(8'($urandom_range(0, 255)));
		end
	endtask

	// hold the sender off until every expected beat has come back
	task automatic wait_drain();
		do @(posedge clk); while (byte_plans.size() != 0 || pending_msgs.size() != 0);
	endtask

	// stimulus
	initial begin
		rx_ch.valid    <= 1'b0;
		rx_ch.rx_byte  <= 8'd0;
		send_idle_pct  = 14;
		recv_stall_pct = 72;
		rand_items     = 0;
		bytes_sent     = 0;
		fail_count     = 0;
		n_realtime     = 0;
		n_message      = 0;
		n_sysex        = 0;
		cur_status     = 8'd0;
		need_cnt       = 2'd0;
		got_cnt        = 2'd0;
		data_pair[0]   = 7'd0;
		data_pair[1]   = 7'd0;
		in_sysex       = 1'b0;

		dir_rows = '{
			row_none(8'h45),                                              // data before any status
			row_out(mimp_pkg::SYS_CLOCK, mimp_pkg::KIND_REALTIME, mimp_pkg::SYS_CLOCK,
				2'd0, 7'h00, 7'h00),
			row_out(mimp_pkg::SYS_START, mimp_pkg::KIND_REALTIME, mimp_pkg::SYS_START,
				2'd0, 7'h00, 7'h00),
			row_out(mimp_pkg::SYS_STOP, mimp_pkg::KIND_REALTIME, mimp_pkg::SYS_STOP,
				2'd0, 7'h00, 7'h00),
			row_none(8'hF4),                                              // undefined system bytes
			row_none(8'hFF),
			row_none(8'h80),                                              // lowest channel status
			row_free(8'h00),
			row_out(8'h7F, mimp_pkg::KIND_MESSAGE, 8'h80, 2'd2, 7'h00, 7'h7F),
			row_none(mimp_pkg::SYS_SOX),
			row_out(8'h00, mimp_pkg::KIND_SYSEX, 8'h00, 2'd0, 7'h00, 7'h00),
			row_out(8'h7F, mimp_pkg::KIND_SYSEX, 8'h00, 2'd0, 7'h7F, 7'h00),
			// realtime in sysex
			row_out(mimp_pkg::SYS_CLOCK, mimp_pkg::KIND_REALTIME, mimp_pkg::SYS_CLOCK,
				2'd0, 7'h00, 7'h00),
			row_none(mimp_pkg::SYS_EOX),
			row_free(8'hD0),                                              // one-byte channel message
			row_free(8'h11),
			row_free(mimp_pkg::SYS_SONG_POS),
			row_free(8'h01),
			row_free(8'h02),
			row_free(mimp_pkg::SYS_MTC_QF),
			row_free(8'h33),
			row_free(8'hEF),                                              // highest channel status
			row_free(8'h40),
			row_free(mimp_pkg::SYS_SOX),                                  // sysex inside a partial message
			row_free(8'h22),
			row_free(mimp_pkg::SYS_EOX)
		};

		@(posedge clk);
		while (!arst_n) @(posedge clk);

		// directed table, last row completes the message split by sysex
		foreach (dir_rows[i])
			put_byte(dir_rows[i].value, dir_rows[i].plan);
		put_byte(8'h41, '0);

		// random phases: sender idles lightly, then heavily, then not at all
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 14;
					recv_stall_pct = 72;
				end
				1: begin
					send_idle_pct  = 72;
					recv_stall_pct = 14;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			while (rand_items < (ph + 1) * PHASE_ITEMS)
				gen_sequence();
			rx_ch.valid <= 1'b0;
			wait_drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d bytes (%0d directed rows) over three idle profiles", bytes_sent,
			$size(dir_rows) + 1);
		$display("checked %0d realtime, %0d message and %0d sysex beats, %0d failures",
			n_realtime, n_message, n_sysex, fail_count + pending_msgs.size());
		if (fail_count == 0 && pending_msgs.size() == 0) begin
			$display("midi_input_message_parser_unit_tb OK");
		end else begin
			$display("midi_input_message_parser_unit_tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== midi_input_message_parser_unit.f =====
src/mimp_pkg.sv
src/mimp_if.sv
src/mimp_decode.sv
src/midi_input_message_parser_unit.sv
src/mimp_checker.sv
dv/midi_input_message_parser_unit_tb.sv
